// ===== design/pcr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcr_pkg
// shared types, widths and helpers of the particle contact resolver
// ----------------------------------------------------------------------------
`default_nettype none

package pcr_pkg;

  localparam int CW         = 21;          // vector component width, signed Q10.10
  localparam int VEC_W      = 63;          // packed vector field width
  localparam int IM_W       = 24;          // inverse mass, unsigned Q8.16
  localparam int BNC_W      = 17;          // restitution, unsigned Q1.16
  localparam int TS_W       = 16;          // time step, unsigned Q0.16
  localparam int R_W        = 17;          // inverse mass share, Q0.16 up to one
  localparam int DIV_STEPS  = R_W;         // one quotient bit per step
  localparam int DIV_STAGES = (DIV_STEPS + 1) / 2;
  localparam int STAGES     = 14;          // register stages from input to output

  localparam logic [TS_W-1:0]  TS_RESET   = 16'd1092;
  localparam logic [BNC_W-1:0] BOUNCE_ONE = 17'd65536;
  localparam logic signed [43:0] SCALAR_CAP = 44'sh400_0000_0000;

  typedef logic signed [CW-1:0] comp_t;
  typedef comp_t [2:0] vec_t;

  // per-beat values that travel alongside the arithmetic
  typedef struct packed {
    vec_t              v1;
    vec_t              v2;
    vec_t              p1;
    vec_t              p2;
    vec_t              n;
    comp_t             pen;
    logic [BNC_W-1:0]  bounce;
    logic              two;
    logic              tim_nz;
    logic              imp;
    logic              sep;
  } ctx_t;

  typedef struct packed {
    logic  sat;
    comp_t val;
  } clamp_t;

  function automatic clamp_t clamp_comp(input logic signed [47:0] x);
    clamp_t r;
    r.sat = 1'b0;
    r.val = x[CW-1:0];
    if (x > $signed(48'((1 << (CW - 1)) - 1))) begin
      r.sat = 1'b1;
      r.val = {1'b0, {(CW-1){1'b1}}};
    end else if (x < -$signed(48'(1 << (CW - 1)))) begin
      r.sat = 1'b1;
      r.val = {1'b1, {(CW-1){1'b0}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/pcr_in_if.sv =====
// ----------------------------------------------------------------------------
// pcr_in_if
// contact channel: valid/ready handshake with one contact per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface pcr_in_if;
  import pcr_pkg::*;

  logic              valid;
  logic              ready;
  logic [VEC_W-1:0]  first_velocity;
  logic [VEC_W-1:0]  second_velocity;
  logic [VEC_W-1:0]  first_acceleration;
  logic [VEC_W-1:0]  second_acceleration;
  logic [VEC_W-1:0]  first_position;
  logic [VEC_W-1:0]  second_position;
  logic [VEC_W-1:0]  contact_normal;
  logic [IM_W-1:0]   first_inverse_mass;
  logic [IM_W-1:0]   second_inverse_mass;
  logic signed [CW-1:0] penetration_depth;
  logic [BNC_W-1:0]  bounce_factor;
  logic              second_present;

  modport source (
    output valid, first_velocity, second_velocity, first_acceleration,
           second_acceleration, first_position, second_position, contact_normal,
           first_inverse_mass, second_inverse_mass, penetration_depth,
           bounce_factor, second_present,
    input  ready
  );

  modport sink (
    input  valid, first_velocity, second_velocity, first_acceleration,
           second_acceleration, first_position, second_position, contact_normal,
           first_inverse_mass, second_inverse_mass, penetration_depth,
           bounce_factor, second_present,
    output ready
  );

endinterface

`default_nettype wire

// ===== design/pcr_out_if.sv =====
// ----------------------------------------------------------------------------
// pcr_out_if
// result channel: valid/ready handshake with one resolved contact per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface pcr_out_if;
  import pcr_pkg::*;

  logic              valid;
  logic              ready;
  logic [VEC_W-1:0]  first_new_velocity;
  logic [VEC_W-1:0]  second_new_velocity;
  logic [VEC_W-1:0]  first_new_position;
  logic [VEC_W-1:0]  second_new_position;
  logic              impulse_applied;
  logic              separation_applied;
  logic              saturated;

  modport source (
    output valid, first_new_velocity, second_new_velocity, first_new_position,
           second_new_position, impulse_applied, separation_applied, saturated,
    input  ready
  );

  modport sink (
    input  valid, first_new_velocity, second_new_velocity, first_new_position,
           second_new_position, impulse_applied, separation_applied, saturated,
    output ready
  );

endinterface

`default_nettype wire

// ===== design/particle_contact_resolver_core.sv =====
// ----------------------------------------------------------------------------
// particle_contact_resolver_core
// impulse and penetration resolution of one particle contact per beat
// ----------------------------------------------------------------------------
// throughput: one contact per cycle unless result.ready stalls the output;
//   every stage has its own valid bit and refills as soon as the stage
//   after it moves, so bubbles close up
// the depth is set by the 17-step restoring divider (two steps per stage)
//   that forms the inverse mass shares, plus the multiply chain after it
// reset: synchronous, clears all valid bits and loads time_step with 1092
`default_nettype none

module particle_contact_resolver_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  time_step_wr_en,
  input  wire logic [pcr_pkg::TS_W-1:0] time_step_wr_data,
  pcr_in_if.sink                     contact,
  pcr_out_if.source                  result
);
  import pcr_pkg::*;

  localparam int L = STAGES;

  // time step register
  logic [TS_W-1:0] ts;

  always_ff @(posedge clk) begin
    if (rst) begin
      ts <= TS_RESET;
    end else if (time_step_wr_en) begin
      ts <= time_step_wr_data;
    end
  end

  // stage control: a stage loads when it is empty or the next one moves
  logic [L-1:0] vld;
  logic [L-1:0] adv;

  always_comb begin
    adv[L-1] = !vld[L-1] || result.ready;
    for (int k = L - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign contact.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= contact.valid;
      for (int k = 1; k < L; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 0: unpack, relative velocity and acceleration, summed inverse mass
  ctx_t               ctx [0:L-2];
  ctx_t               ctx_in;
  logic signed [CW:0] rv_in [3];
  logic signed [CW:0] da_in [3];
  logic signed [CW:0] rv0 [3];
  logic signed [CW:0] da0 [3];
  logic [IM_W-1:0]    im1_0, im2_0, im2_eff;
  logic [IM_W:0]      tim0, tim_in;

  always_comb begin
    ctx_in.two    = contact.second_present;
    ctx_in.pen    = contact.penetration_depth;
    ctx_in.bounce = (contact.bounce_factor > BOUNCE_ONE) ? BOUNCE_ONE : contact.bounce_factor;
    for (int k = 0; k < 3; k++) begin
      ctx_in.v1[k] = contact.first_velocity[CW*k +: CW];
      ctx_in.v2[k] = contact.second_velocity[CW*k +: CW];
      ctx_in.p1[k] = contact.first_position[CW*k +: CW];
      ctx_in.p2[k] = contact.second_position[CW*k +: CW];
      ctx_in.n[k]  = contact.contact_normal[CW*k +: CW];
      // scenery contact: the second particle counts as resting
      rv_in[k] = $signed(ctx_in.v1[k])
               - (contact.second_present ? $signed(ctx_in.v2[k]) : $signed((CW+1)'(0)));
      da_in[k] = $signed(contact.first_acceleration[CW*k +: CW])
               - (contact.second_present ? $signed(contact.second_acceleration[CW*k +: CW])
                                         : $signed((CW+1)'(0)));
    end
    im2_eff       = contact.second_present ? contact.second_inverse_mass : '0;
    tim_in        = {1'b0, contact.first_inverse_mass} + {1'b0, im2_eff};
    ctx_in.tim_nz = (tim_in != '0);
    ctx_in.imp    = 1'b0;
    ctx_in.sep    = ctx_in.tim_nz && (contact.penetration_depth > 0);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rv0    <= rv_in;
      da0    <= da_in;
      im1_0  <= contact.first_inverse_mass;
      im2_0  <= im2_eff;
      tim0   <= tim_in;
    end
  end

  // context travels beside the math; the impulse flag joins at stage 2
  logic signed [44:0] sv_sum, ad_sum;
  logic signed [42:0] prv [3];
  logic signed [42:0] pda [3];
  ctx_t               ctx2_in;

  always_comb begin
    sv_sum = prv[0] + prv[1] + prv[2];
    ad_sum = pda[0] + pda[1] + pda[2];
  end

  always_comb begin
    ctx2_in     = ctx[1];
    ctx2_in.imp = ctx[1].tim_nz && (sv_sum <= 0);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) ctx[0] <= ctx_in;
    for (int k = 1; k < L - 1; k++) begin
      if (adv[k]) ctx[k] <= (k == 2) ? ctx2_in : ctx[k-1];
    end
  end

  // shares im1/tim and im2/tim, ready at stage 9
  logic [R_W-1:0] r1_9, r2_9;

  pcr_div u_div (
    .clk (clk),
    .en  (adv[DIV_STAGES:1]),
    .im1 (im1_0),
    .im2 (im2_0),
    .tim (tim0),
    .r1  (r1_9),
    .r2  (r2_9)
  );

  // stage 1: per-component products of the dot products
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int k = 0; k < 3; k++) begin
        prv[k] <= rv0[k] * $signed(ctx[0].n[k]);
        pda[k] <= da0[k] * $signed(ctx[0].n[k]);
      end
    end
  end

  // stage 2: separating velocity and acceleration along the normal (Q20)
  logic signed [44:0] sv2, ad2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sv2 <= sv_sum;
      ad2 <= ad_sum;
    end
  end

  // stage 3: bounce scaling and velocity built up over one step
  logic signed [44:0] sv3;
  logic signed [63:0] svb3;
  logic signed [61:0] adt3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sv3  <= sv2;
      svb3 <= -sv2 * $signed({1'b0, ctx[2].bounce});
      adt3 <= ad2 * $signed({1'b0, ts});
    end
  end

  // stage 4: back to Q20, arithmetic shift gives floor
  logic signed [44:0] sv4;
  logic signed [47:0] ns4;
  logic signed [45:0] acc4;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sv4  <= sv3;
      ns4  <= 48'(svb3 >>> 16);
      acc4 <= 46'(adt3 >>> 16);
    end
  end

  // stage 5: restitution applied to the accumulated term
  logic signed [44:0] sv5;
  logic signed [47:0] ns5;
  logic               acc_neg5;
  logic signed [63:0] ba5;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      sv5      <= sv4;
      ns5      <= ns4;
      acc_neg5 <= acc4[45];
      ba5      <= $signed({1'b0, ctx[4].bounce}) * acc4;
    end
  end

  // stage 6: target velocity (build-up added and clamped at zero when acc is negative), then the needed change
  logic signed [48:0] ns_sum, ns_fin;
  logic signed [49:0] dd6;
  logic signed [46:0] dlt [4];

  always_comb begin
    ns_sum = ns5 + 49'(ba5 >>> 16);
    ns_fin = 49'(ns5);
    if (acc_neg5) ns_fin = (ns_sum < 0) ? '0 : ns_sum;
    dd6 = ns_fin - sv5;
  end

  // stages 6 to 9: hold the change until the shares arrive
  always_ff @(posedge clk) begin
    if (adv[6]) dlt[0] <= dd6[46:0];
    for (int k = 1; k < 4; k++) begin
      if (adv[6+k]) dlt[k] <= dlt[k-1];
    end
  end

  // stage 10: split the change and the penetration by the shares
  logic signed [64:0] sp1, sp2;
  logic signed [38:0] mp1, mp2;

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      sp1 <= dlt[3] * $signed({1'b0, r1_9});
      sp2 <= dlt[3] * $signed({1'b0, r2_9});
      mp1 <= $signed(ctx[9].pen) * $signed({1'b0, r1_9});
      mp2 <= $signed(ctx[9].pen) * $signed({1'b0, r2_9});
    end
  end

  // stage 11: per-particle scalars, impulse capped at 2^42
  logic signed [64:0] sh1, sh2;
  logic signed [43:0] s1, s2;
  logic signed [22:0] m1, m2;

  always_comb begin
    sh1 = sp1 >>> 16;
    sh2 = sp2 >>> 16;
  end

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      s1 <= (sh1 > 65'(SCALAR_CAP)) ? SCALAR_CAP : sh1[43:0];
      s2 <= (sh2 > 65'(SCALAR_CAP)) ? SCALAR_CAP : sh2[43:0];
      m1 <= 23'(mp1 >>> 16);
      m2 <= 23'(mp2 >>> 16);
    end
  end

  // stage 12: scale the normal; the second particle moves the other way
  logic signed [44:0] vd1 [3];
  logic signed [44:0] vd2 [3];
  logic signed [33:0] pd1 [3];
  logic signed [33:0] pd2 [3];
  logic signed [CW:0] nneg [3];
  logic signed [64:0] pv1 [3];
  logic signed [65:0] pv2 [3];
  logic signed [43:0] pq1 [3];
  logic signed [44:0] pq2 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nneg[k] = -$signed({ctx[11].n[k][CW-1], ctx[11].n[k]});
      pv1[k]  = $signed(ctx[11].n[k]) * s1;
      pv2[k]  = nneg[k] * s2;
      pq1[k]  = $signed(ctx[11].n[k]) * m1;
      pq2[k]  = nneg[k] * m2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[12]) begin
      for (int k = 0; k < 3; k++) begin
        vd1[k] <= 45'(pv1[k] >>> 20);
        vd2[k] <= 45'(pv2[k] >>> 20);
        pd1[k] <= 34'(pq1[k] >>> 10);
        pd2[k] <= 34'(pq2[k] >>> 10);
      end
    end
  end

  // stage 13: add, saturate, pack into the output register
  clamp_t             cv1 [3];
  clamp_t             cv2 [3];
  clamp_t             cp1 [3];
  clamp_t             cp2 [3];
  vec_t               nv1, nv2, np1, np2;
  logic               sat_n;
  ctx_t               c12;

  always_comb begin
    c12   = ctx[L-2];
    nv1   = c12.v1;
    nv2   = c12.v2;
    np1   = c12.p1;
    np2   = c12.p2;
    sat_n = 1'b0;
    for (int k = 0; k < 3; k++) begin
      cv1[k] = clamp_comp($signed(c12.v1[k]) + vd1[k]);
      cv2[k] = clamp_comp($signed(c12.v2[k]) + vd2[k]);
      cp1[k] = clamp_comp($signed(c12.p1[k]) + pd1[k]);
      cp2[k] = clamp_comp($signed(c12.p2[k]) + pd2[k]);
      if (c12.imp) begin
        nv1[k] = cv1[k].val;
        sat_n  = sat_n | cv1[k].sat;
        if (c12.two) begin
          nv2[k] = cv2[k].val;
          sat_n  = sat_n | cv2[k].sat;
        end
      end
      if (c12.sep) begin
        np1[k] = cp1[k].val;
        sat_n  = sat_n | cp1[k].sat;
        if (c12.two) begin
          np2[k] = cp2[k].val;
          sat_n  = sat_n | cp2[k].sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[L-1]) begin
      result.first_new_velocity  <= nv1;
      result.second_new_velocity <= nv2;
      result.first_new_position  <= np1;
      result.second_new_position <= np2;
      result.impulse_applied     <= c12.imp;
      result.separation_applied  <= c12.sep;
      result.saturated           <= sat_n;
    end
  end

  assign result.valid = vld[L-1];

`ifndef SYNTHESIS
  // nothing in flight right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("pipeline not empty after reset");

  // clamping only happens on a component that was updated
  a_sat_cause: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |-> result.impulse_applied || result.separation_applied)
    else $error("saturation flagged with no update");

  // the two truncated shares add up to one or one lsb below
  a_share_sum: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STAGES] && ctx[DIV_STAGES].tim_nz && ctx[DIV_STAGES].two |->
      ({1'b0, r1_9} + {1'b0, r2_9} == {1'b0, BOUNCE_ONE})
      || ({1'b0, r1_9} + {1'b0, r2_9} == {1'b0, BOUNCE_ONE} - 18'd1))
    else $error("inverse mass shares inconsistent");

  // an approaching contact never needs a negative velocity change
  a_delta_sign: assert property (@(posedge clk) disable iff (rst)
    vld[9] && ctx[9].imp |-> !dlt[3][46])
    else $error("negative velocity change on impulse");
`endif

endmodule

`default_nettype wire

// ===== design/pcr_div.sv =====
// ----------------------------------------------------------------------------
// pcr_div
// pipelined restoring divider: both inverse mass shares im/tim in Q0.16
// ----------------------------------------------------------------------------
`default_nettype none

module pcr_div (
  input  wire logic                          clk,
  input  wire logic [pcr_pkg::DIV_STAGES-1:0] en,
  input  wire logic [pcr_pkg::IM_W-1:0]       im1,
  input  wire logic [pcr_pkg::IM_W-1:0]       im2,
  input  wire logic [pcr_pkg::IM_W:0]         tim,
  output logic      [pcr_pkg::R_W-1:0]        r1,
  output logic      [pcr_pkg::R_W-1:0]        r2
);
  import pcr_pkg::*;

  typedef struct packed {
    logic [IM_W+1:0] rem;
    logic [R_W-1:0]  q;
  } dstep_t;

  // one quotient bit; the first step takes the dividend without a shift
  function automatic dstep_t div_step(input dstep_t x, input logic [IM_W:0] d, input int t);
    dstep_t y;
    y = x;
    if (t > 0) y.rem = {x.rem[IM_W:0], 1'b0};
    if (y.rem >= {1'b0, d}) begin
      y.rem = y.rem - {1'b0, d};
      y.q[R_W-1-t] = 1'b1;
    end
    return y;
  endfunction

  dstep_t          a_q [0:DIV_STAGES];
  dstep_t          b_q [0:DIV_STAGES];
  logic [IM_W:0]   d_q [0:DIV_STAGES];

  assign a_q[0] = '{rem: (IM_W+2)'(im1), q: '0};
  assign b_q[0] = '{rem: (IM_W+2)'(im2), q: '0};
  assign d_q[0] = tim;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    dstep_t a_n, b_n;

    always_comb begin
      a_n = a_q[s];
      b_n = b_q[s];
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < DIV_STEPS) begin
          a_n = div_step(a_n, d_q[s], 2 * s + j);
          b_n = div_step(b_n, d_q[s], 2 * s + j);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        a_q[s+1] <= a_n;
        b_q[s+1] <= b_n;
        d_q[s+1] <= d_q[s];
      end
    end
  end

  assign r1 = a_q[DIV_STAGES].q;
  assign r2 = b_q[DIV_STAGES].q;

endmodule

`default_nettype wire
